// ===== src/vrtg_pkg.sv =====
// Shared types and constants of the video raster timing generator.
package vrtg_pkg;

  localparam int unsigned DIM_W     = 12;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [PIX_W-1:0] BLANK_PIXEL = 8'hBB;

  localparam logic [DIM_W-1:0] RST_ACTIVE_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0] RST_ACTIVE_HEIGHT = 12'd480;
  localparam logic [DIM_W-1:0] RST_LINE_BLANK    = 12'd160;
  localparam logic [DIM_W-1:0] RST_FRAME_BLANK   = 12'd40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_WIDTH  = 2'd0,
    REG_ACTIVE_HEIGHT = 2'd1,
    REG_LINE_BLANK    = 2'd2,
    REG_FRAME_BLANK   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SCAN = 2'd1,
    PH_IRQ  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [DIM_W-1:0] active_width;
    logic [DIM_W-1:0] active_height;
    logic [DIM_W-1:0] line_blank;
    logic [DIM_W-1:0] frame_blank;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             line_active;
    logic             frame_active;
    logic             frame_irq;
    logic             fifo_pop;
    logic             underflow;
  } res_t;

endpackage

// ===== src/vrtg_if.sv =====
// Valid/ready channel interfaces for pixel ticks, results and configuration writes.
interface vrtg_pix_if;
  logic       valid;
  logic       ready;
  logic       fifo_not_empty;
  logic [7:0] fifo_byte;

  modport source (output valid, output fifo_not_empty, output fifo_byte, input ready);
  modport sink   (input valid, input fifo_not_empty, input fifo_byte, output ready);
endinterface

interface vrtg_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       line_active;
  logic       frame_active;
  logic       frame_irq;
  logic       fifo_pop;
  logic       underflow;

  modport source (output valid, output pixel, output line_active, output frame_active,
                  output frame_irq, output fifo_pop, output underflow, input ready);
  modport sink   (input valid, input pixel, input line_active, input frame_active,
                  input frame_irq, input fifo_pop, input underflow, output ready);
endinterface

interface vrtg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/vrtg_raster.sv =====
// Raster scan state machine: phase, row and column counters, held outputs.
module vrtg_raster (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   fifo_not_empty_i,
  input  logic [vrtg_pkg::PIX_W-1:0] fifo_byte_i,
  input  vrtg_pkg::cfg_t         cfg_i,
  output vrtg_pkg::res_t         res_o
);
  import vrtg_pkg::*;

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] row_q, row_d, col_q, col_d;
  logic [1:0]       irq_ticks_q, irq_ticks_d;
  logic [PIX_W-1:0] held_pixel_q;
  logic             held_lv_q, held_fv_q;

  logic [CNT_W-1:0] rows, cols, cur_row, cur_col, col_inc, row_inc;
  logic             empty_frame, do_scan, col_wrap, frame_done, active;
  logic [1:0]       ticks_inc;

  assign rows = {1'b0, cfg_i.active_height} + {1'b0, cfg_i.frame_blank};
  assign cols = {1'b0, cfg_i.line_blank} + {1'b0, cfg_i.active_width};
  assign empty_frame = (rows == '0) || (cols == '0);

  // A frame starts on the same tick that finds the FIFO non-empty.
  assign do_scan = (phase_q == PH_SCAN) ||
                   ((phase_q == PH_IDLE) && fifo_not_empty_i && !empty_frame);
  assign cur_row = (phase_q == PH_IDLE) ? '0 : row_q;
  assign cur_col = (phase_q == PH_IDLE) ? '0 : col_q;

  assign col_inc    = cur_col + 1'b1;
  assign row_inc    = cur_row + 1'b1;
  assign col_wrap   = (col_inc >= cols) || (col_inc == '0);
  assign frame_done = col_wrap && ((row_inc >= rows) || (row_inc == '0));
  assign ticks_inc  = irq_ticks_q + 1'b1;

  // Next phase and counters.
  always_comb begin
    phase_d     = phase_q;
    irq_ticks_d = irq_ticks_q;
    row_d       = row_q;
    col_d       = col_q;
    case (phase_q)
      PH_IDLE: begin
        if (fifo_not_empty_i && empty_frame) begin
          phase_d     = PH_IRQ;
          irq_ticks_d = 2'd1;
          row_d       = '0;
          col_d       = '0;
        end
      end
      PH_SCAN: begin
      end
      PH_IRQ: begin
        irq_ticks_d = ticks_inc;
        if (ticks_inc == 2'd3) begin
          irq_ticks_d = '0;
          phase_d     = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
    if (do_scan) begin
      col_d = col_wrap ? '0 : col_inc;
      row_d = col_wrap ? (frame_done ? '0 : row_inc) : cur_row;
      if (frame_done) begin
        phase_d     = PH_IRQ;
        irq_ticks_d = '0;
      end else begin
        phase_d = PH_SCAN;
      end
    end
  end

  // Result of this tick.
  always_comb begin
    active             = 1'b0;
    res_o.pixel        = held_pixel_q;
    res_o.line_active  = held_lv_q;
    res_o.frame_active = held_fv_q;
    res_o.frame_irq    = (phase_q == PH_IRQ) ||
                         ((phase_q == PH_IDLE) && fifo_not_empty_i && empty_frame);
    res_o.fifo_pop     = 1'b0;
    res_o.underflow    = 1'b0;
    if (do_scan) begin
      active = (cur_row < {1'b0, cfg_i.active_height}) &&
               (cur_col >= {1'b0, cfg_i.line_blank});
      if (!active) begin
        res_o.pixel = BLANK_PIXEL;
      end else if (fifo_not_empty_i) begin
        res_o.pixel = fifo_byte_i;
      end
      res_o.line_active  = active;
      res_o.frame_active = cur_row < {1'b0, cfg_i.active_height};
      res_o.fifo_pop     = active && fifo_not_empty_i;
      res_o.underflow    = active && !fifo_not_empty_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      row_q        <= '0;
      col_q        <= '0;
      irq_ticks_q  <= '0;
      held_pixel_q <= '0;
      held_lv_q    <= 1'b0;
      held_fv_q    <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      row_q        <= row_d;
      col_q        <= col_d;
      irq_ticks_q  <= irq_ticks_d;
      held_pixel_q <= res_o.pixel;
      held_lv_q    <= res_o.line_active;
      held_fv_q    <= res_o.frame_active;
    end
  end

  a_idle_counters_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (row_q == '0) && (col_q == '0))
    else $error("raster counters not cleared while idle");

  a_ticks_only_in_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IRQ) |-> (irq_ticks_q == '0))
    else $error("interrupt tick count set outside the interrupt phase");

  a_pop_xor_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_o.fifo_pop && res_o.underflow))
    else $error("pop and underflow in the same tick");

  a_irq_quiet_fifo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.frame_irq |-> !res_o.fifo_pop && !res_o.underflow)
    else $error("FIFO activity during an interrupt tick");

endmodule

// ===== src/vrtg_out_reg.sv =====
// Result register that decouples the raster state from the result channel.
module vrtg_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  vrtg_pkg::res_t res_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output vrtg_pkg::res_t res_o,
  output logic           in_ready_o
);
  import vrtg_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // A new tick may enter while the held result leaves in the same cycle.
  assign in_ready_o  = !valid_q || out_ready_i;
  assign valid_d     = load_i || (valid_q && !out_ready_i);
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  a_empty_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q |-> in_ready_o)
    else $error("empty result register refused a new tick");

endmodule

// ===== src/video_raster_timing_generator_unit.sv =====
// Top level of the video raster timing generator.
// Latency: a result is offered on the cycle after its input transfer.
// Throughput: one pixel tick per cycle; a new tick is taken whenever the result
// register is empty or its result is taken in the same cycle.
// Reset (rst_ni low, asynchronous): idle phase, counters and held outputs zero,
// registers at 640 x 480 with 160 blanking columns and 40 blanking rows.
module video_raster_timing_generator_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  vrtg_pix_if.sink   pix_i,
  vrtg_cfg_if.sink   cfg_i,
  vrtg_res_if.source res_o
);
  import vrtg_pkg::*;

  cfg_t     cfg_q;
  res_t     res_d, res_q;
  logic     in_ready, accept;
  cfg_reg_e cfg_idx;

  assign cfg_i.ready = 1'b1;
  assign cfg_idx     = cfg_reg_e'(cfg_i.index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_width  <= RST_ACTIVE_WIDTH;
      cfg_q.active_height <= RST_ACTIVE_HEIGHT;
      cfg_q.line_blank    <= RST_LINE_BLANK;
      cfg_q.frame_blank   <= RST_FRAME_BLANK;
    end else if (cfg_i.valid) begin
      case (cfg_idx)
        REG_ACTIVE_WIDTH:  cfg_q.active_width  <= cfg_i.data;
        REG_ACTIVE_HEIGHT: cfg_q.active_height <= cfg_i.data;
        REG_LINE_BLANK:    cfg_q.line_blank    <= cfg_i.data;
        REG_FRAME_BLANK:   cfg_q.frame_blank   <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  assign pix_i.ready = in_ready;
  assign accept      = pix_i.valid && in_ready;

  vrtg_raster u_raster (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (accept),
    .fifo_not_empty_i (pix_i.fifo_not_empty),
    .fifo_byte_i      (pix_i.fifo_byte),
    .cfg_i            (cfg_q),
    .res_o            (res_d)
  );

  vrtg_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (res_d),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .res_o       (res_q),
    .in_ready_o  (in_ready)
  );

  assign res_o.pixel        = res_q.pixel;
  assign res_o.line_active  = res_q.line_active;
  assign res_o.frame_active = res_q.frame_active;
  assign res_o.frame_irq    = res_q.frame_irq;
  assign res_o.fifo_pop     = res_q.fifo_pop;
  assign res_o.underflow    = res_q.underflow;

endmodule

// ===== verif/tb_video_raster_timing_generator_unit.sv =====
// Self-checking testbench of the video raster timing generator with a scan predictor.
`timescale 1ns / 100ps

module tb_video_raster_timing_generator_unit;
  import vrtg_pkg::*;

  typedef struct packed {
    logic             not_empty;
    logic [PIX_W-1:0] head;
  } fifo_tick_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  vrtg_pix_if pix ();
  vrtg_cfg_if cfg ();
  vrtg_res_if res ();

  video_raster_timing_generator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Pending FIFO ticks, expected raster outputs and the predictor's copy of the block.
  fifo_tick_t       tick_q[$];
  res_t             raster_out_q[$];
  int unsigned      mismatch_count     = 0;
  int unsigned      sender_gap_pct     = 9;
  int unsigned      receiver_stall_pct = 85;

  cfg_t             timing = '{RST_ACTIVE_WIDTH, RST_ACTIVE_HEIGHT,
                               RST_LINE_BLANK, RST_FRAME_BLANK};
  phase_e           scan_phase = PH_IDLE;
  logic [CNT_W-1:0] row_c      = '0;
  logic [CNT_W-1:0] col_c      = '0;
  logic [1:0]       irq_n      = '0;
  logic [PIX_W-1:0] held_pix   = '0;
  logic             held_lv    = 1'b0;
  logic             held_fv    = 1'b0;

  fifo_tick_t       next_tick;
  logic             holding;
  res_t             want;

  // Advances the raster by one pixel-clock tick and returns what the block should drive.
  function automatic res_t raster_tick(logic not_empty, logic [PIX_W-1:0] head);
    res_t             r;
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;
    logic             on_active;
    rows = CNT_W'(timing.active_height) + CNT_W'(timing.frame_blank);
    cols = CNT_W'(timing.line_blank) + CNT_W'(timing.active_width);
    if (scan_phase == PH_IDLE && not_empty) begin
      row_c = '0;
      col_c = '0;
      irq_n = '0;
      // An empty frame goes straight to the interrupt ticks.
      if (rows == 0 || cols == 0) begin
        scan_phase = PH_IRQ;
      end else begin
        scan_phase = PH_SCAN;
      end
    end
    r              = '0;
    r.pixel        = held_pix;
    r.line_active  = held_lv;
    r.frame_active = held_fv;
    if (scan_phase == PH_IRQ) begin
      r.frame_irq = 1'b1;
      irq_n       = irq_n + 2'd1;
      if (irq_n >= 2'd3) begin
        irq_n      = '0;
        scan_phase = PH_IDLE;
      end
    end else if (scan_phase == PH_SCAN) begin
      on_active = (row_c < CNT_W'(timing.active_height)) &&
                  (col_c >= CNT_W'(timing.line_blank));
      if (!on_active) begin
        held_pix = BLANK_PIXEL;
      end else if (not_empty) begin
        held_pix   = head;
        r.fifo_pop = 1'b1;
      end else begin
        r.underflow = 1'b1;
      end
      held_lv        = on_active;
      held_fv        = row_c < CNT_W'(timing.active_height);
      r.pixel        = held_pix;
      r.line_active  = held_lv;
      r.frame_active = held_fv;
      // Counters left beyond a shrunken total wrap on their next advance.
      col_c = col_c + 1'b1;
      if (col_c >= cols || col_c == 0) begin
        col_c = '0;
        row_c = row_c + 1'b1;
        if (row_c >= rows || row_c == 0) begin
          row_c      = '0;
          scan_phase = PH_IRQ;
          irq_n      = '0;
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string tag, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, tag, exp_v, act_v);
    end
  endtask

  // Pixel tick driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix.valid          <= 1'b0;
      pix.fifo_not_empty <= 1'b0;
      pix.fifo_byte      <= '0;
    end else begin
      holding = pix.valid && !pix.ready;
      if (pix.valid && pix.ready) begin
        raster_out_q.push_back(raster_tick(pix.fifo_not_empty, pix.fifo_byte));
      end
      if (!holding) begin
        if (tick_q.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct) begin
          next_tick           = tick_q.pop_front();
          pix.valid          <= 1'b1;
          pix.fifo_not_empty <= next_tick.not_empty;
          pix.fifo_byte      <= next_tick.head;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (raster_out_q.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: unexpected result, expected none, actual pixel %0h", $time,
                   res.pixel);
        end else begin
          want = raster_out_q.pop_front();
          check_field("pixel", 32'(want.pixel), 32'(res.pixel));
          check_field("line_active", 32'(want.line_active), 32'(res.line_active));
          check_field("frame_active", 32'(want.frame_active), 32'(res.frame_active));
          check_field("frame_irq", 32'(want.frame_irq), 32'(res.frame_irq));
          check_field("fifo_pop", 32'(want.fifo_pop), 32'(res.fifo_pop));
          check_field("underflow", 32'(want.underflow), 32'(res.underflow));
        end
      end
      res.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  function automatic void queue_tick(logic not_empty, logic [PIX_W-1:0] head);
    tick_q.push_back('{not_empty, head});
  endfunction

  // Returns at a falling edge once every queued tick has been transferred and checked.
  task automatic drain();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || pix.valid || raster_out_q.size() != 0);
  endtask

  // Called at a rising edge; valid stays high across back-to-back writes.
  task automatic write_timing_reg(cfg_reg_e idx, logic [DIM_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk_i);
    while (!(cfg.valid && cfg.ready));
    case (idx)
      REG_ACTIVE_WIDTH:  timing.active_width  = value;
      REG_ACTIVE_HEIGHT: timing.active_height = value;
      REG_LINE_BLANK:    timing.line_blank    = value;
      REG_FRAME_BLANK:   timing.frame_blank   = value;
      default: ;
    endcase
  endtask

  task automatic program_timing(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                                logic [DIM_W-1:0] lb, logic [DIM_W-1:0] fb);
    write_timing_reg(REG_ACTIVE_WIDTH, w);
    write_timing_reg(REG_ACTIVE_HEIGHT, h);
    write_timing_reg(REG_LINE_BLANK, lb);
    write_timing_reg(REG_FRAME_BLANK, fb);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] lb;
    logic [DIM_W-1:0] fb;
    logic             ne;
    int unsigned      fed;
    cfg.valid = 1'b0;
    cfg.index = REG_ACTIVE_WIDTH;
    cfg.data  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset geometry: idle ticks hold zeros, then the scan starts in blanking columns.
    queue_tick(1'b0, 8'h00);
    queue_tick(1'b0, 8'hFF);
    queue_tick(1'b1, 8'h00);
    queue_tick(1'b1, 8'hFF);
    queue_tick(1'b0, 8'h55);
    drain();

    // Shrinking the frame mid-line: the column counter is past the new total.
    @(posedge clk_i);
    program_timing(12'd1, 12'd1, 12'd1, 12'd0);
    @(negedge clk_i);
    queue_tick(1'b1, 8'hFF);
    queue_tick(1'b0, 8'h00);
    queue_tick(1'b0, 8'h00);
    queue_tick(1'b0, 8'h00);
    queue_tick(1'b0, 8'h00);
    queue_tick(1'b1, 8'h00);
    queue_tick(1'b1, 8'h80);
    queue_tick(1'b1, 8'h01);
    queue_tick(1'b1, 8'h02);
    queue_tick(1'b1, 8'h04);
    // An empty FIFO at the first active pixel repeats the blanking value.
    queue_tick(1'b1, 8'h2A);
    queue_tick(1'b0, 8'h10);
    queue_tick(1'b1, 8'h20);
    queue_tick(1'b1, 8'h40);
    queue_tick(1'b0, 8'h08);

    for (int round = 0; round < 12; round++) begin
      if (round == 4) begin
        sender_gap_pct     = 85;
        receiver_stall_pct = 9;
      end else if (round == 8) begin
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
      end
      drain();
      @(posedge clk_i);
      if (round == 5) begin
        program_timing(12'd4095, 12'd4095, 12'd4095, 12'd4095);
      end else begin
        w  = DIM_W'($urandom_range(1, 6));
        h  = DIM_W'($urandom_range(1, 4));
        lb = DIM_W'($urandom_range(1, 4));
        fb = DIM_W'($urandom_range(0, 3));
        // Now and then one dimension goes to its maximum.
        case ($urandom_range(0, 11))
          0: w  = 12'd4095;
          1: h  = 12'd4095;
          2: lb = 12'd4095;
          3: fb = 12'd4095;
          default: ;
        endcase
        program_timing(w, h, lb, fb);
      end
      @(negedge clk_i);
      fed = 0;
      while (fed < 130) begin
        ne = ($urandom_range(0, 9) != 0);
        queue_tick(ne, PIX_W'($urandom_range(0, 255)));
        fed++;
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && raster_out_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== video_raster_timing_generator_unit.f =====
src/vrtg_pkg.sv
src/vrtg_if.sv
src/vrtg_raster.sv
src/vrtg_out_reg.sv
src/video_raster_timing_generator_unit.sv
verif/tb_video_raster_timing_generator_unit.sv
